>>> rtl/spq_pkg.sv
// ============================================================================
// Sorted priority queue package
// Shared types, sizes and codes for the sorted priority queue.
// ============================================================================
package spq_pkg;

    // Number of entries the queue can hold.
    localparam int DEPTH = 16;
    // Stored payload width; payloads are kept to their low bits.
    localparam int PQ_PAY_W = 32;

    localparam int PQ_AW    = $clog2(DEPTH);
    localparam int PQ_CW    = $clog2(DEPTH + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;

    // Request codes.
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] in_key;
        logic [PAY_W-1:0]        in_payload;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [KEY_W-1:0] out_key;
        logic [PAY_W-1:0]        out_payload;
        logic [OCC_W-1:0]        occupancy;
    } t_resp;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PQ_PAY_W-1:0]     pay;
    } t_entry;

endpackage

>>> rtl/spq_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ============================================================================
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sorted_priority_queue_top.sv
// ============================================================================
// Sorted priority queue (maximum first)
// Holds up to DEPTH signed-key entries in descending order in one RAM.
// ============================================================================
// The queue keeps its entries in a circular buffer in a single RAM, head
// entry (largest key) at the head pointer, so an extract only reads the head
// and advances the pointer: the RAM read is issued on the request beat and
// the result is registered from S_EXTR. An insert walks from the tail towards
// the head through one shared signed comparator, moving each entry whose key
// is not greater than the new key one slot back, one entry per cycle since
// the RAM has a single read and a single write port, until it finds a larger
// key or reaches the head. Among equal keys the newest entry therefore sits
// nearest the head. An extract from an empty queue, an insert into a full
// queue and an insert into an empty queue load their result on the request
// beat itself. One request is worked on at a time; the request channel is
// ready again in the cycle after the result is loaded, provided the result
// register is empty or being drained. Every result reports the occupancy
// after the request, and key and payload are zero except on a successful
// extract. The RAM needs no clearing after reset: only slots below the
// occupancy are ever read, and each was written first.
// ============================================================================
module sorted_priority_queue_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spq_pkg::t_req    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output spq_pkg::t_resp   o_out_data
);

    import spq_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request beat
    localparam logic [1:0] S_EXTR  = 2'd1;  // head entry being read
    localparam logic [1:0] S_SCAN  = 2'd2;  // walking from the tail
    localparam logic [1:0] S_PLACE = 2'd3;  // new entry goes to the head

    logic [1:0]              r_state, n_state;
    logic [PQ_CW-1:0]        r_count, n_count;
    logic [PQ_AW-1:0]        r_head,  n_head;
    logic [PQ_AW-1:0]        r_idx,   n_idx;
    logic signed [KEY_W-1:0] r_key,   n_key;
    logic [PQ_PAY_W-1:0]     r_pay,   n_pay;
    logic                    r_out_valid, n_out_valid;
    t_resp                   r_out,   n_out;

    logic                    w_we;
    logic [PQ_AW-1:0]        w_waddr;
    t_entry                  w_wdata;
    logic                    w_re;
    logic [PQ_AW-1:0]        w_raddr;
    t_entry                  w_rd;
    logic                    w_in_acc;

    // Offset from the head, wrapped round the buffer.
    function automatic logic [PQ_AW-1:0] slot_addr(input logic [PQ_AW-1:0] base,
                                                   input logic [PQ_AW-1:0] off);
        logic [PQ_AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PQ_AW + 1)'(DEPTH)) begin
            sum = sum - (PQ_AW + 1)'(DEPTH);
        end
        return sum[PQ_AW-1:0];
    endfunction

    function automatic t_resp make_resp(input logic [STAT_W-1:0] status,
                                        input logic [KEY_W-1:0]  key,
                                        input logic [PAY_W-1:0]  pay,
                                        input logic [PQ_CW-1:0]  occ);
        t_resp r;
        r.status      = status;
        r.out_key     = key;
        r.out_payload = pay;
        r.occupancy   = OCC_W'(occ);
        return r;
    endfunction

    // A new request is only taken when the result register will be free,
    // so a finishing request can always load its result.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    spq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_key       = r_key;
        n_pay       = r_pay;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_head;
        w_wdata     = '{key: r_key, pay: r_pay};
        w_re        = 1'b0;
        w_raddr     = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_key = i_in_data.in_key;
                    n_pay = PQ_PAY_W'(i_in_data.in_payload);
                    if (i_in_data.req_type == REQ_EXTRACT) begin
                        if (r_count == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = make_resp(ST_EMPTY, '0, '0, r_count);
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = r_head;
                            n_state = S_EXTR;
                        end
                    end else if (r_count == PQ_CW'(DEPTH)) begin
                        n_out_valid = 1'b1;
                        n_out       = make_resp(ST_FULL, '0, '0, r_count);
                    end else if (r_count == '0) begin
                        // Empty queue: the entry simply becomes the head.
                        w_we        = 1'b1;
                        w_waddr     = r_head;
                        w_wdata     = '{key: i_in_data.in_key,
                                        pay: PQ_PAY_W'(i_in_data.in_payload)};
                        n_count     = PQ_CW'(1);
                        n_out_valid = 1'b1;
                        n_out       = make_resp(ST_OK, '0, '0, PQ_CW'(1));
                    end else begin
                        // Fetch the tail entry and start the walk.
                        w_re    = 1'b1;
                        w_raddr = slot_addr(r_head, PQ_AW'(r_count - PQ_CW'(1)));
                        n_idx   = PQ_AW'(r_count);
                        n_state = S_SCAN;
                    end
                end
            end

            S_EXTR: begin
                n_count     = r_count - PQ_CW'(1);
                n_head      = slot_addr(r_head, PQ_AW'(1));
                n_out_valid = 1'b1;
                n_out       = make_resp(ST_OK, w_rd.key, PAY_W'(w_rd.pay),
                                        r_count - PQ_CW'(1));
                n_state     = S_IDLE;
            end

            S_SCAN: begin
                // w_rd holds the entry just ahead of slot r_idx.
                w_we    = 1'b1;
                w_waddr = slot_addr(r_head, r_idx);
                if (w_rd.key > r_key) begin
                    w_wdata     = '{key: r_key, pay: r_pay};
                    n_count     = r_count + PQ_CW'(1);
                    n_out_valid = 1'b1;
                    n_out       = make_resp(ST_OK, '0, '0, r_count + PQ_CW'(1));
                    n_state     = S_IDLE;
                end else begin
                    w_wdata = w_rd;
                    n_idx   = r_idx - PQ_AW'(1);
                    if (r_idx == PQ_AW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = slot_addr(r_head, r_idx - PQ_AW'(2));
                    end
                end
            end

            S_PLACE: begin
                w_we        = 1'b1;
                w_waddr     = r_head;
                w_wdata     = '{key: r_key, pay: r_pay};
                n_count     = r_count + PQ_CW'(1);
                n_out_valid = 1'b1;
                n_out       = make_resp(ST_OK, '0, '0, r_count + PQ_CW'(1));
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_key <= n_key;
        r_pay <= n_pay;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PQ_CW'(DEPTH))
        else $error("occupancy exceeds the queue depth");

    a_busy_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result register occupied while a request is in progress");

    a_extract_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXTR) |=> (r_count == $past(r_count) - PQ_CW'(1)))
        else $error("extract did not lower the occupancy by one");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx != '0) && (r_count != '0))
        else $error("tail walk reached the head without placing the entry");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |->
            (o_out_data.out_key == '0) && (o_out_data.out_payload == '0))
        else $error("failed request carries a non-zero key or payload");

endmodule
